### hdl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and fixed constants of the five-point Lagrange interpolator.
// ----------------------------------------------------------------------------
package lfp_pkg;

    // Ring of five sample slots, addressed by a three-bit slot number
    localparam int RING_SIZE = 5;
    typedef logic [2:0] t_slot;

    // Register stages from the input register to the output register
    localparam int PIPE_STAGES = 8;

    // The polynomial is carried scaled by 24 = 8 * 3
    localparam int COEF_GAIN  = 24;
    localparam int GAIN_SHIFT = 3;
    localparam int GAIN_ODD   = 3;

    // Fold slot numbers 5, 6 and 7 back onto 0, 1 and 2
    function automatic t_slot lfp_reduce_slot(input t_slot slot);
        t_slot res;
        if (slot >= t_slot'(RING_SIZE)) begin
            res = slot - t_slot'(RING_SIZE);
        end else begin
            res = slot;
        end
        return res;
    endfunction

endpackage

### hdl/lfp_in_if.sv
// ----------------------------------------------------------------------------
// lfp_in_if
// Input stream: five ring-slot samples, the start slot and the offset.
// ----------------------------------------------------------------------------
interface lfp_in_if
    import lfp_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_slot_0;
    logic signed [SAMPLE_BITS-1:0] sample_slot_1;
    logic signed [SAMPLE_BITS-1:0] sample_slot_2;
    logic signed [SAMPLE_BITS-1:0] sample_slot_3;
    logic signed [SAMPLE_BITS-1:0] sample_slot_4;
    t_slot                         start_slot;
    logic [OFFSET_BITS-1:0]        offset;

    modport source (
        output valid, sample_slot_0, sample_slot_1, sample_slot_2,
               sample_slot_3, sample_slot_4, start_slot, offset,
        input  ready
    );

    modport sink (
        input  valid, sample_slot_0, sample_slot_1, sample_slot_2,
               sample_slot_3, sample_slot_4, start_slot, offset,
        output ready
    );
endinterface

### hdl/lfp_out_if.sv
// ----------------------------------------------------------------------------
// lfp_out_if
// Output stream: one interpolated sample per transaction.
// ----------------------------------------------------------------------------
interface lfp_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] interpolated;

    modport source (
        output valid, interpolated,
        input  ready
    );

    modport sink (
        input  valid, interpolated,
        output ready
    );
endinterface

### hdl/lfp_horner_step.sv
// ----------------------------------------------------------------------------
// lfp_horner_step
// One registered Horner step: add the next coefficient to the rounded
// previous product, multiply by the offset and add the rounding half.
// ----------------------------------------------------------------------------
module lfp_horner_step #(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic signed [SAMPLE_BITS+OFFSET_BITS+9:0]     i_p,
    input  logic signed [SAMPLE_BITS+6:0]                 i_c,
    input  logic [OFFSET_BITS-1:0]                        i_u,
    output logic signed [SAMPLE_BITS+OFFSET_BITS+9:0]     o_p
);
    localparam int HW = SAMPLE_BITS + 9;
    localparam int PW = HW + OFFSET_BITS + 1;
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (OFFSET_BITS - 1));

    logic signed [HW-1:0] w_h;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] r_p;

    // Take the rounded previous product and add the coefficient
    assign w_h    = HW'(i_c) + $signed(i_p[OFFSET_BITS +: HW]);
    assign w_prod = w_h * $signed({1'b0, i_u}) + HALF;

    // Hold the product until the stage advances
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_prod;
        end
    end

    assign o_p = r_p;
endmodule

### hdl/lagrange_five_point_interpolator.sv
// ----------------------------------------------------------------------------
// lagrange_five_point_interpolator
// Five-point Lagrange interpolation of a ring of samples at a fractional
// offset. The block is an eight-stage pipeline that takes one transaction
// every cycle while the output is not stalled: a coefficient stage, four
// Horner multiply stages, and the rounding, reciprocal-divide and
// saturation stages. Every stage has its own valid bit and advances when
// it is empty or its successor advances, so a stalled output keeps earlier
// stages filling and nothing is dropped or repeated. Start slots 5 to 7
// act as 0 to 2.
// The result is rounded half up and saturated to the sample range.
// ----------------------------------------------------------------------------
module lagrange_five_point_interpolator
    import lfp_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfp_in_if.sink    i_item,
    lfp_out_if.source o_result
);
    localparam int SB = SAMPLE_BITS;
    localparam int OB = OFFSET_BITS;
    localparam int CW = SB + 7;
    localparam int HW = SB + 9;
    localparam int PW = HW + OB + 1;
    localparam int K  = SB + 2;
    localparam int NS = PIPE_STAGES;

    localparam logic signed [HW:0] LIM =
        {{(HW - SB - 3){1'b0}}, 2'b11, {(SB + 2){1'b0}}};
    localparam logic [K-1:0] RECIP = K'(((64'd1 << K) - 64'd1) / 64'd3);
    localparam logic signed [SB-1:0] Y_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] Y_MIN = {1'b1, {(SB - 1){1'b0}}};

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_result.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_v[0] = w_en[0] ? i_item.valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_item.ready = w_en[0];

    // ---- stage 0: rotate the ring and form the scaled coefficients ----
    t_slot                w_start;
    logic signed [SB-1:0] w_s0, w_s1, w_s2, w_s3, w_s4;
    logic signed [CW-1:0] w_e0, w_e1, w_e2, w_e3, w_e4;
    logic signed [CW-1:0] w_c0, w_c1, w_c2, w_c3, w_c4;

    assign w_start = lfp_reduce_slot(i_item.start_slot);

    always_comb begin
        unique case (w_start)
            3'd1: begin
                w_s0 = i_item.sample_slot_1; w_s1 = i_item.sample_slot_2;
                w_s2 = i_item.sample_slot_3; w_s3 = i_item.sample_slot_4;
                w_s4 = i_item.sample_slot_0;
            end
            3'd2: begin
                w_s0 = i_item.sample_slot_2; w_s1 = i_item.sample_slot_3;
                w_s2 = i_item.sample_slot_4; w_s3 = i_item.sample_slot_0;
                w_s4 = i_item.sample_slot_1;
            end
            3'd3: begin
                w_s0 = i_item.sample_slot_3; w_s1 = i_item.sample_slot_4;
                w_s2 = i_item.sample_slot_0; w_s3 = i_item.sample_slot_1;
                w_s4 = i_item.sample_slot_2;
            end
            3'd4: begin
                w_s0 = i_item.sample_slot_4; w_s1 = i_item.sample_slot_0;
                w_s2 = i_item.sample_slot_1; w_s3 = i_item.sample_slot_2;
                w_s4 = i_item.sample_slot_3;
            end
            default: begin
                w_s0 = i_item.sample_slot_0; w_s1 = i_item.sample_slot_1;
                w_s2 = i_item.sample_slot_2; w_s3 = i_item.sample_slot_3;
                w_s4 = i_item.sample_slot_4;
            end
        endcase
    end

    assign w_e0 = CW'(w_s0);
    assign w_e1 = CW'(w_s1);
    assign w_e2 = CW'(w_s2);
    assign w_e3 = CW'(w_s3);
    assign w_e4 = CW'(w_s4);

    assign w_c4 = w_e0 - (w_e1 <<< 2) + (w_e2 <<< 2) + (w_e2 <<< 1)
                - (w_e3 <<< 2) + w_e4;
    assign w_c3 = (w_e4 <<< 1) - (w_e0 <<< 1) + (w_e1 <<< 2) - (w_e3 <<< 2);
    assign w_c2 = (w_e1 <<< 4) + (w_e3 <<< 4) - (w_e2 <<< 5) + (w_e2 <<< 1)
                - w_e0 - w_e4;
    assign w_c1 = (w_e0 <<< 1) - (w_e4 <<< 1) + (w_e3 <<< 4) - (w_e1 <<< 4);
    assign w_c0 = (w_e2 <<< 4) + (w_e2 <<< 3);

    logic signed [CW-1:0] r_c0_s0, r_c1_s0, r_c2_s0, r_c3_s0, r_c4_s0;
    logic [OB-1:0]        r_u_s0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_c0_s0 <= w_c0;
            r_c1_s0 <= w_c1;
            r_c2_s0 <= w_c2;
            r_c3_s0 <= w_c3;
            r_c4_s0 <= w_c4;
            r_u_s0  <= i_item.offset;
        end
    end

    // ---- stages 1 to 4: Horner steps, coefficients delayed alongside ----
    logic signed [PW-1:0] w_p_s1, w_p_s2, w_p_s3, w_p_s4;
    logic signed [CW-1:0] r_c0_s1, r_c1_s1, r_c2_s1, r_c3_s1;
    logic signed [CW-1:0] r_c0_s2, r_c1_s2, r_c2_s2;
    logic signed [CW-1:0] r_c0_s3, r_c1_s3;
    logic signed [CW-1:0] r_c0_s4;
    logic [OB-1:0]        r_u_s1, r_u_s2, r_u_s3;

    lfp_horner_step #(.SAMPLE_BITS(SB), .OFFSET_BITS(OB)) u_step_4 (
        .i_clk (i_clk), .i_en (w_en[1]), .i_p ('0),
        .i_c (r_c4_s0), .i_u (r_u_s0), .o_p (w_p_s1)
    );

    lfp_horner_step #(.SAMPLE_BITS(SB), .OFFSET_BITS(OB)) u_step_3 (
        .i_clk (i_clk), .i_en (w_en[2]), .i_p (w_p_s1),
        .i_c (r_c3_s1), .i_u (r_u_s1), .o_p (w_p_s2)
    );

    lfp_horner_step #(.SAMPLE_BITS(SB), .OFFSET_BITS(OB)) u_step_2 (
        .i_clk (i_clk), .i_en (w_en[3]), .i_p (w_p_s2),
        .i_c (r_c2_s2), .i_u (r_u_s2), .o_p (w_p_s3)
    );

    lfp_horner_step #(.SAMPLE_BITS(SB), .OFFSET_BITS(OB)) u_step_1 (
        .i_clk (i_clk), .i_en (w_en[4]), .i_p (w_p_s3),
        .i_c (r_c1_s3), .i_u (r_u_s3), .o_p (w_p_s4)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_c0_s1 <= r_c0_s0;
            r_c1_s1 <= r_c1_s0;
            r_c2_s1 <= r_c2_s0;
            r_c3_s1 <= r_c3_s0;
            r_u_s1  <= r_u_s0;
        end
        if (w_en[2]) begin
            r_c0_s2 <= r_c0_s1;
            r_c1_s2 <= r_c1_s1;
            r_c2_s2 <= r_c2_s1;
            r_u_s2  <= r_u_s1;
        end
        if (w_en[3]) begin
            r_c0_s3 <= r_c0_s2;
            r_c1_s3 <= r_c1_s2;
            r_u_s3  <= r_u_s2;
        end
        if (w_en[4]) begin
            r_c0_s4 <= r_c0_s3;
        end
    end

    // ---- stage 5: last add, rounding bias, limit check, divide by 8 ----
    logic signed [HW:0] w_hp;
    logic signed [HW:0] w_bias;
    logic               w_hi, w_lo;
    logic [K-1:0]       r_wb_s5;
    logic               r_hi_s5, r_lo_s5;

    assign w_hp   = (HW + 1)'(r_c0_s4) + (HW + 1)'($signed(w_p_s4[OB +: HW]))
                  + (HW + 1)'(COEF_GAIN / 2);
    assign w_hi   = (w_hp >= LIM);
    assign w_lo   = (w_hp < -LIM);
    assign w_bias = (w_hp >>> GAIN_SHIFT) + (LIM >>> GAIN_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_wb_s5 <= w_bias[K-1:0];
            r_hi_s5 <= w_hi;
            r_lo_s5 <= w_lo;
        end
    end

    // ---- stage 6: reciprocal multiply for the divide by 3 ----
    logic [2*K-1:0] w_qp;
    logic [K-1:0]   r_q0_s6, r_wb_s6;
    logic           r_hi_s6, r_lo_s6;

    assign w_qp = (2 * K)'(r_wb_s5) * (2 * K)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_q0_s6 <= w_qp[2*K-1:K];
            r_wb_s6 <= r_wb_s5;
            r_hi_s6 <= r_hi_s5;
            r_lo_s6 <= r_lo_s5;
        end
    end

    // ---- stage 7: correct the quotient, remove the bias, saturate ----
    logic [K-1:0]         w_rem, w_q;
    logic signed [SB-1:0] w_y;
    logic signed [SB-1:0] r_y;

    assign w_rem = r_wb_s6 - (r_q0_s6 + (r_q0_s6 << 1));
    assign w_q   = r_q0_s6 + K'(w_rem >= K'(GAIN_ODD));

    always_comb begin
        if (r_hi_s6) begin
            w_y = Y_MAX;
        end else if (r_lo_s6) begin
            w_y = Y_MIN;
        end else begin
            w_y = {~w_q[SB-1], w_q[SB-2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_y <= w_y;
        end
    end

    assign o_result.valid        = r_v[NS-1];
    assign o_result.interpolated = r_y;

    // ---- checks ----
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> i_item.ready
    ) else $error("input stalled with an empty output stage");

    a_sat_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] |-> !(r_hi_s6 && r_lo_s6)
    ) else $error("both saturation limits flagged");

    a_recip_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && !r_hi_s6 && !r_lo_s6) |-> (w_rem < K'(2 * GAIN_ODD))
    ) else $error("reciprocal quotient off by more than one");

    a_stall_holds_stage: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-2] && !w_en[NS-1]) |=> r_v[NS-2]
    ) else $error("stalled pipeline stage lost its transaction");

endmodule
